### hw/rtl/btw_pkg.sv
// ----------------------------------------------------------------------------
// btw_pkg: shared types and constants for the two-wire master
// Command codes, field widths and slot-sequence constants.
// ----------------------------------------------------------------------------
package btw_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef logic [4:0] phase_t;
  typedef logic [1:0] sub_t;

  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam phase_t     WR_BITS_END   = 5'd24;
  localparam phase_t     WR_ACK_SCL_HI = 5'd25;
  localparam phase_t     RD_BITS_END   = 5'd16;
  localparam phase_t     RD_ACK_SCL_HI = 5'd17;
  localparam sub_t       SUB_LAST      = 2'd2;

endpackage

### hw/rtl/btw_in_if.sv
// ----------------------------------------------------------------------------
// btw_in_if: command channel of the two-wire master
// Carries one slot word: command, write byte, master acknowledge, SDA sample.
// ----------------------------------------------------------------------------
interface btw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] wr_byte;
  logic       master_ack;
  logic       sda_in;

  modport source (output valid, cmd, wr_byte, master_ack, sda_in, input ready);
  modport sink   (input valid, cmd, wr_byte, master_ack, sda_in, output ready);
endinterface

### hw/rtl/btw_out_if.sv
// ----------------------------------------------------------------------------
// btw_out_if: result channel of the two-wire master
// Carries one slot word: line levels, status and the last read/ack results.
// ----------------------------------------------------------------------------
interface btw_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rd_byte;
  logic       ack_seen;

  modport source (output valid, scl_release, sda_release, busy_res, done_res,
                  rd_byte, ack_seen, input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res,
                  rd_byte, ack_seen, output ready);
endinterface

### hw/rtl/bit_banged_two_wire_master_unit.sv
// ----------------------------------------------------------------------------
// bit_banged_two_wire_master_unit: open-drain two-wire master, slot engine
// Each accepted input word is one half-period slot; each gives one result.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per timing slot: a command (start, stop, write
//   byte, read byte or none), the byte to write, the acknowledge to give on
//   a read, and the SDA level seen during the previous slot. A command is
//   taken only while the engine is idle; one given while busy is dropped.
//   out_ch returns one word per input word: SCL and SDA release levels for
//   the next slot, busy and done flags, the last read byte and the last
//   write acknowledge.
//   The result of a word sits in the output register on the cycle after it
//   is accepted. One word is taken per cycle while the receiver keeps taking
//   results, set by the single state update between input and output register.
//   in_ch.ready is high while the output register is empty or being taken,
//   so a stalled receiver holds the result and stalls the input side.
//   Reset returns the engine to idle with both lines released, the read
//   byte and acknowledge flag at zero and the output register empty.
// ----------------------------------------------------------------------------
module bit_banged_two_wire_master_unit
  import btw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  btw_in_if.sink        in_ch,
  btw_out_if.source     out_ch
);

  // engine state
  logic [2:0] active_cmd_r, active_cmd_nxt;
  phase_t     slot_phase_r, slot_phase_nxt;
  sub_t       sub_r, sub_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_flag_r, ack_flag_nxt;
  logic       ack_to_send_r, ack_to_send_nxt;
  logic [7:0] last_rd_r, last_rd_nxt;

  // output register
  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_busy_r, out_done_r, out_ack_r;
  logic [7:0] out_rd_r;

  // slot working values
  logic       accept;
  logic       launch;
  logic [2:0] cur_cmd;
  phase_t     phase;
  sub_t       sub;
  logic [7:0] shift_cur;
  logic       scl_slot, sda_slot, busy, last;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // latch a new command only when idle and the code is a real one
  always_comb begin
    launch = (active_cmd_r == CMD_NONE) &&
             ((in_ch.cmd == CMD_START) || (in_ch.cmd == CMD_STOP) ||
              (in_ch.cmd == CMD_WRITE) || (in_ch.cmd == CMD_READ));
    cur_cmd         = launch ? in_ch.cmd : active_cmd_r;
    phase           = launch ? '0 : slot_phase_r;
    sub             = launch ? '0 : sub_r;
    shift_cur       = launch ? ((in_ch.cmd == CMD_WRITE) ? in_ch.wr_byte : 8'h00) : shift_r;
    ack_to_send_nxt = launch ? in_ch.master_ack : ack_to_send_r;
  end

  // run one slot of the active command
  always_comb begin
    scl_slot     = scl_r;
    sda_slot     = sda_r;
    shift_nxt    = shift_cur;
    ack_flag_nxt = ack_flag_r;
    last_rd_nxt  = last_rd_r;
    busy         = 1'b1;
    last         = 1'b0;
    unique case (cur_cmd)
      CMD_NONE: begin
        busy = 1'b0;
      end
      CMD_START: begin
        if (phase == 5'd0) begin
          sda_slot = 1'b1;
          scl_slot = 1'b1;
        end else if (phase == 5'd1) begin
          sda_slot = 1'b0;
        end else begin
          scl_slot = 1'b0;
          last     = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase == 5'd0) begin
          sda_slot = 1'b0;
        end else if (phase == 5'd1) begin
          scl_slot = 1'b1;
        end else begin
          sda_slot = 1'b1;
          last     = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (phase < WR_BITS_END) begin
          if (sub == 2'd0) begin
            sda_slot  = |(shift_cur & MSB_MASK);
            shift_nxt = {shift_cur[6:0], 1'b0};
          end else if (sub == 2'd1) begin
            scl_slot = 1'b1;
          end else begin
            scl_slot = 1'b0;
          end
        end else if (phase == WR_BITS_END) begin
          sda_slot = 1'b1;
        end else if (phase == WR_ACK_SCL_HI) begin
          scl_slot = 1'b1;
        end else begin
          ack_flag_nxt = !in_ch.sda_in;
          scl_slot     = 1'b0;
          last         = 1'b1;
        end
      end
      CMD_READ: begin
        if (phase < RD_BITS_END) begin
          if (!phase[0]) begin
            if (phase == 5'd0) sda_slot = 1'b1;
            scl_slot = 1'b1;
          end else begin
            shift_nxt = {shift_cur[6:0], in_ch.sda_in};
            scl_slot  = 1'b0;
          end
        end else if (phase == RD_BITS_END) begin
          sda_slot = !ack_to_send_nxt;
        end else if (phase == RD_ACK_SCL_HI) begin
          scl_slot = 1'b1;
        end else begin
          scl_slot    = 1'b0;
          last_rd_nxt = shift_cur;
          last        = 1'b1;
        end
      end
      default: begin
        // unknown command: return to idle, keep the lines
        last = 1'b1;
      end
    endcase
  end

  // advance or finish the slot sequence
  always_comb begin
    active_cmd_nxt = cur_cmd;
    slot_phase_nxt = phase;
    sub_nxt        = sub;
    scl_nxt        = scl_slot;
    sda_nxt        = sda_slot;
    if (busy) begin
      if (last) begin
        active_cmd_nxt = CMD_NONE;
        slot_phase_nxt = '0;
        sub_nxt        = '0;
        if (cur_cmd == CMD_READ) sda_nxt = 1'b1;
      end else begin
        slot_phase_nxt = phase + 5'd1;
        sub_nxt        = (sub == SUB_LAST) ? 2'd0 : sub + 2'd1;
      end
    end
  end

  // update state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cmd_r  <= CMD_NONE;
      slot_phase_r  <= '0;
      sub_r         <= '0;
      shift_r       <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_flag_r    <= 1'b0;
      ack_to_send_r <= 1'b0;
      last_rd_r     <= '0;
    end else if (accept) begin
      active_cmd_r  <= active_cmd_nxt;
      slot_phase_r  <= slot_phase_nxt;
      sub_r         <= sub_nxt;
      shift_r       <= shift_nxt;
      scl_r         <= scl_nxt;
      sda_r         <= sda_nxt;
      ack_flag_r    <= ack_flag_nxt;
      ack_to_send_r <= ack_to_send_nxt;
      last_rd_r     <= last_rd_nxt;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_scl_r  <= scl_slot;
      out_sda_r  <= sda_slot;
      out_busy_r <= busy;
      out_done_r <= busy && last;
      out_rd_r   <= last_rd_nxt;
      out_ack_r  <= ack_flag_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_release = out_scl_r;
  assign out_ch.sda_release = out_sda_r;
  assign out_ch.busy_res    = out_busy_r;
  assign out_ch.done_res    = out_done_r;
  assign out_ch.rd_byte     = out_rd_r;
  assign out_ch.ack_seen    = out_ack_r;

endmodule

### hw/rtl/btw_checker.sv
// ----------------------------------------------------------------------------
// btw_checker: port-level checks for the two-wire master
// Watches the handshakes and status flags seen at the top-level ports.
// ----------------------------------------------------------------------------
module btw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl,
  input logic       out_sda,
  input logic       out_busy,
  input logic       out_done,
  input logic [7:0] out_rd,
  input logic       out_ack
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_scl, out_sda, out_busy, out_done, out_rd, out_ack}))
    else $error("result word changed while stalled");

  // done only on a busy slot
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_busy)
    else $error("done without busy");

  // input side is open whenever the output register is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output register");

  // every accepted word yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind bit_banged_two_wire_master_unit btw_checker u_btw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_scl   (out_ch.scl_release),
  .out_sda   (out_ch.sda_release),
  .out_busy  (out_ch.busy_res),
  .out_done  (out_ch.done_res),
  .out_rd    (out_ch.rd_byte),
  .out_ack   (out_ch.ack_seen)
);

### tb/sv/bit_banged_two_wire_master_unit_test.sv
// ----------------------------------------------------------------------------
// bit_banged_two_wire_master_unit_test: self-checking bench for the slot engine
// Feeds slot words through the command channel and compares every result word
// with a line-level model of the engine or a pinned value. A directed table of
// stimulus comes first, then random start/write/read/stop transactions with
// noise commands. Both channels idle at random; the receiver also holds off for
// one long stretch so that the engine fills up and stalls its input.
// ----------------------------------------------------------------------------
module bit_banged_two_wire_master_unit_test;
  import btw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes with no meaning to the engine
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // Slots taken by each command
  localparam int START_SLOTS = 3;
  localparam int STOP_SLOTS  = 3;
  localparam int WRITE_SLOTS = 27;
  localparam int READ_SLOTS  = 19;

  localparam int RAND_ITEMS  = 1900;
  localparam int CALM_FROM   = 700;
  localparam int CALM_TO     = 1000;
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_LEN    = 300;
  localparam int IDLE_PCT    = 34;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wr_byte;
    logic       master_ack;
    logic       sda_in;
  } word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rd_byte;
    logic       ack;
  } slot_t;

  typedef struct {
    word_t w;
    int    reps;
    bit    pinned;
    slot_t exp;
  } dir_row_t;

  typedef struct {
    bit    pinned;
    slot_t exp;
  } pin_note_t;

  logic clk;
  logic rst_n;

  btw_in_if  in_if ();
  btw_out_if out_if ();

  bit_banged_two_wire_master_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Engine model state
  cmd_t       eng_cmd;
  phase_t     eng_phase;
  logic [7:0] eng_shift;
  logic [7:0] eng_last_rd;
  logic       eng_scl;
  logic       eng_sda;
  logic       eng_ack;
  logic       eng_mack;

  slot_t      slot_expected_q [$];
  pin_note_t  pinned_q [$];
  dir_row_t   dir_table [$];
  int         errors;
  bit         calm;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the engine model by one slot and return the result word
  function automatic slot_t step_engine(input word_t w);
    slot_t r;
    logic  last;
    logic  rel_after;
    last      = 1'b0;
    rel_after = 1'b0;
    if (eng_cmd == CMD_NONE && w.cmd >= CMD_START && w.cmd <= CMD_READ) begin
      eng_cmd   = cmd_t'(w.cmd);
      eng_phase = '0;
      eng_shift = (w.cmd == CMD_WRITE) ? w.wr_byte : 8'h00;
      eng_mack  = w.master_ack;
    end
    r = '0;
    if (eng_cmd != CMD_NONE) begin
      case (eng_cmd)
        CMD_START: begin
          if (eng_phase == 0) begin
            eng_sda = 1'b1;
            eng_scl = 1'b1;
          end else if (eng_phase == 1) begin
            eng_sda = 1'b0;
          end else begin
            eng_scl = 1'b0;
            last    = 1'b1;
          end
        end
        CMD_STOP: begin
          if (eng_phase == 0) eng_sda = 1'b0;
          else if (eng_phase == 1) eng_scl = 1'b1;
          else begin
            eng_sda = 1'b1;
            last    = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (eng_phase < WR_BITS_END) begin
            case (eng_phase % 3)
              0: begin
                eng_sda   = (eng_shift & MSB_MASK) != 8'h00;
                eng_shift = eng_shift << 1;
              end
              1: eng_scl = 1'b1;
              default: eng_scl = 1'b0;
            endcase
          end else if (eng_phase == WR_BITS_END) begin
            eng_sda = 1'b1;
          end else if (eng_phase == WR_ACK_SCL_HI) begin
            eng_scl = 1'b1;
          end else begin
            // slave pulling SDA low during the ack slot means acknowledged
            eng_ack = !w.sda_in;
            eng_scl = 1'b0;
            last    = 1'b1;
          end
        end
        CMD_READ: begin
          if (eng_phase < RD_BITS_END) begin
            if (!eng_phase[0]) begin
              if (eng_phase == 0) eng_sda = 1'b1;
              eng_scl = 1'b1;
            end else begin
              eng_shift = {eng_shift[6:0], w.sda_in};
              eng_scl   = 1'b0;
            end
          end else if (eng_phase == RD_BITS_END) begin
            eng_sda = !eng_mack;
          end else if (eng_phase == RD_ACK_SCL_HI) begin
            eng_scl = 1'b1;
          end else begin
            eng_scl     = 1'b0;
            eng_last_rd = eng_shift;
            last        = 1'b1;
            rel_after   = 1'b1;
          end
        end
        default: last = 1'b1;
      endcase
      r.busy = 1'b1;
      if (last) begin
        r.done    = 1'b1;
        eng_cmd   = CMD_NONE;
        eng_phase = '0;
      end else begin
        eng_phase = eng_phase + 1'b1;
      end
    end
    r.scl     = eng_scl;
    r.sda     = eng_sda;
    r.rd_byte = eng_last_rd;
    r.ack     = eng_ack;
    // release SDA once the read's last slot has gone out
    if (rel_after) eng_sda = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] c, input logic [7:0] b,
                                  input logic m, input logic s, input int n,
                                  input bit pin, input slot_t e);
    dir_row_t row;
    row.w      = '{cmd: c, wr_byte: b, master_ack: m, sda_in: s};
    row.reps   = n;
    row.pinned = pin;
    row.exp    = e;
    dir_table.push_back(row);
  endfunction

  // Offer one word, idling first at random, and hold it until taken
  task automatic offer_word(input word_t w, input bit pin, input slot_t e);
    pin_note_t note;
    note.pinned = pin;
    note.exp    = e;
    pinned_q.push_back(note);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= w.cmd;
    in_if.wr_byte    <= w.wr_byte;
    in_if.master_ack <= w.master_ack;
    in_if.sda_in     <= w.sda_in;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Predict on every accepted input word
  always @(posedge clk) begin : in_mon
    word_t     w;
    pin_note_t note;
    slot_t     predicted;
    if (rst_n && in_if.valid && in_if.ready) begin
      w    = '{cmd: in_if.cmd, wr_byte: in_if.wr_byte,
               master_ack: in_if.master_ack, sda_in: in_if.sda_in};
      note = pinned_q.pop_front();
      predicted = step_engine(w);
      slot_expected_q.push_back(note.pinned ? note.exp : predicted);
    end
  end

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin : out_mon
    slot_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (slot_expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = slot_expected_q.pop_front();
        if (out_if.scl_release !== e.scl) begin
          $error("scl_release: expected %0b, got %0b", e.scl, out_if.scl_release);
          errors++;
        end
        if (out_if.sda_release !== e.sda) begin
          $error("sda_release: expected %0b, got %0b", e.sda, out_if.sda_release);
          errors++;
        end
        if (out_if.busy_res !== e.busy) begin
          $error("busy_res: expected %0b, got %0b", e.busy, out_if.busy_res);
          errors++;
        end
        if (out_if.done_res !== e.done) begin
          $error("done_res: expected %0b, got %0b", e.done, out_if.done_res);
          errors++;
        end
        if (out_if.rd_byte !== e.rd_byte) begin
          $error("rd_byte: expected %02h, got %02h", e.rd_byte, out_if.rd_byte);
          errors++;
        end
        if (out_if.ack_seen !== e.ack) begin
          $error("ack_seen: expected %0b, got %0b", e.ack, out_if.ack_seen);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off
  initial begin : rx_side
    int unsigned cyc;
    cyc = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      cyc++;
      if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) out_if.ready <= 1'b0;
      else if (calm) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("bit_banged_two_wire_master_unit test failed");
    $finish;
  end

  // Main stimulus
  initial begin : stim
    word_t w;
    int    busy_items;
    int    slots_left;
    int    roll;
    int    guard;
    bit    in_txn;
    slot_t idle_reset;

    errors      = 0;
    calm        = 1'b0;
    eng_cmd     = CMD_NONE;
    eng_phase   = '0;
    eng_shift   = 8'h00;
    eng_last_rd = 8'h00;
    eng_scl     = 1'b1;
    eng_sda     = 1'b1;
    eng_ack     = 1'b0;
    eng_mack    = 1'b0;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cmd        <= CMD_NONE;
    in_if.wr_byte    <= 8'h00;
    in_if.master_ack <= 1'b0;
    in_if.sda_in     <= 1'b0;

    idle_reset = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

    // Directed table: idle, unused codes, start with a dropped command,
    // write with ack and no ack, reads with both acks, stop, busy noise
    add_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 2,  1'b1, idle_reset);
    add_row(CMD_RSVD5, 8'hFF, 1'b1, 1'b1, 1,  1'b1, idle_reset);
    add_row(CMD_RSVD6, 8'hFF, 1'b1, 1'b1, 1,  1'b1, idle_reset);
    add_row(CMD_RSVD7, 8'hFF, 1'b1, 1'b1, 1,  1'b1, idle_reset);
    add_row(CMD_START, 8'h00, 1'b0, 1'b0, 1,  1'b1,
            '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1,  1'b1,
            '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 1,  1'b1,
            '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0});
    add_row(CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1,  1'b1,
            '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_READ,  8'h00, 1'b1, 1'b1, 25, 1'b0, '0);
    add_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 1,  1'b1,
            '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1});
    add_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 1,  1'b1,
            '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
    add_row(CMD_WRITE, 8'h00, 1'b0, 1'b1, 27, 1'b0, '0);
    add_row(CMD_READ,  8'h00, 1'b1, 1'b1, 19, 1'b0, '0);
    add_row(CMD_READ,  8'hFF, 1'b0, 1'b0, 19, 1'b0, '0);
    add_row(CMD_STOP,  8'h00, 1'b0, 1'b1, 3,  1'b0, '0);
    add_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 2,  1'b0, '0);
    add_row(CMD_START, 8'hA5, 1'b1, 1'b0, 1,  1'b0, '0);
    add_row(CMD_RSVD7, 8'h5A, 1'b0, 1'b1, 2,  1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      repeat (dir_table[i].reps)
        offer_word(dir_table[i].w, dir_table[i].pinned, dir_table[i].exp);
    end

    // Random transactions; the directed part leaves a transaction open
    busy_items = 0;
    slots_left = 0;
    in_txn     = 1'b1;
    while (busy_items < RAND_ITEMS) begin
      calm = (busy_items >= CALM_FROM && busy_items < CALM_TO);
      w.master_ack = 1'($urandom_range(0, 1));
      w.sda_in     = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) w.wr_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else w.wr_byte = 8'($urandom);
      if (slots_left != 0) begin
        // engine busy: mostly no command, sometimes noise that it drops
        if ($urandom_range(0, 99) < 15) w.cmd = 3'($urandom_range(CMD_NONE, CMD_RSVD7));
        else w.cmd = CMD_NONE;
        slots_left--;
        busy_items++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 15) w.cmd = CMD_NONE;
        else if (roll < 25) w.cmd = 3'($urandom_range(CMD_NONE, CMD_RSVD7));
        else if (!in_txn) w.cmd = CMD_START;
        else begin
          roll = $urandom_range(0, 99);
          if (roll < 45) w.cmd = CMD_WRITE;
          else if (roll < 80) w.cmd = CMD_READ;
          else w.cmd = CMD_STOP;
        end
        case (w.cmd)
          CMD_START: begin
            in_txn     = 1'b1;
            slots_left = START_SLOTS - 1;
            busy_items++;
          end
          CMD_STOP: begin
            in_txn     = 1'b0;
            slots_left = STOP_SLOTS - 1;
            busy_items++;
          end
          CMD_WRITE: begin
            slots_left = WRITE_SLOTS - 1;
            busy_items++;
          end
          CMD_READ: begin
            slots_left = READ_SLOTS - 1;
            busy_items++;
          end
          default: ;
        endcase
      end
      offer_word(w, 1'b0, '0);
    end
    calm = 1'b0;

    // Drain: wait for every expected word, then check that none is left
    in_if.valid <= 1'b0;
    guard = 0;
    while (slot_expected_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (slot_expected_q.size() != 0) begin
      $error("%0d expected result words never arrived", slot_expected_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("bit_banged_two_wire_master_unit test passed");
    end else begin
      $display("bit_banged_two_wire_master_unit test failed");
    end
    $finish;
  end

endmodule
